// ----- design/chs_pkg.sv -----
// Shared types and constants for the cosine hemisphere sampler.
`default_nettype none
package chs_pkg;

    typedef struct packed {
        logic [15:0] u_radius;
        logic [15:0] u_angle;
    } request_t;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic [16:0]        dir_height;
        logic [13:0]        density;
    } result_t;

    localparam logic [31:0] KGAIN_Q32   = 32'd2608131496;
    localparam logic [31:0] INV_TAU_Q32 = 32'd683565276;
    localparam logic [16:0] HEIGHT_MAX  = 17'd65536;

    function automatic logic [31:0] atan_turn(input int step);
        logic [31:0] a;
        case (step)
            0:       a = 32'd536870912;
            1:       a = 32'd316933406;
            2:       a = 32'd167458907;
            3:       a = 32'd85004756;
            4:       a = 32'd42667331;
            5:       a = 32'd21354465;
            6:       a = 32'd10679838;
            7:       a = 32'd5340245;
            8:       a = 32'd2670163;
            9:       a = 32'd1335087;
            10:      a = 32'd667544;
            11:      a = 32'd333772;
            12:      a = 32'd166886;
            13:      a = 32'd83443;
            14:      a = 32'd41722;
            15:      a = 32'd20861;
            16:      a = 32'd10430;
            17:      a = 32'd5215;
            18:      a = 32'd2608;
            19:      a = 32'd1304;
            20:      a = 32'd652;
            21:      a = 32'd326;
            22:      a = 32'd163;
            23:      a = 32'd81;
            24:      a = 32'd41;
            25:      a = 32'd20;
            26:      a = 32'd10;
            27:      a = 32'd5;
            28:      a = 32'd3;
            29:      a = 32'd1;
            30:      a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ----- design/chs_sqrt_cell.sv -----
// One result bit of the paired radius and height square roots.
`default_nettype none
module chs_sqrt_cell #(
    parameter int RW  = 34,
    parameter int QW  = 17,
    parameter int BIT = 0
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [RW-1:0] in_rem_r,
    input  wire logic [QW-1:0] in_root_r,
    input  wire logic [RW-1:0] in_rem_h,
    input  wire logic [QW-1:0] in_root_h,
    input  wire logic [15:0]   in_angle,
    output logic               out_valid,
    output logic [RW-1:0]      out_rem_r,
    output logic [QW-1:0]      out_root_r,
    output logic [RW-1:0]      out_rem_h,
    output logic [QW-1:0]      out_root_h,
    output logic [15:0]        out_angle
);
    logic [RW-1:0] test_r;
    logic [RW-1:0] test_h;
    logic [RW-1:0] rem_r_next;
    logic [RW-1:0] rem_h_next;
    logic [QW-1:0] root_r_next;
    logic [QW-1:0] root_h_next;
    logic          valid_reg;
    logic [RW-1:0] rem_r_reg;
    logic [RW-1:0] rem_h_reg;
    logic [QW-1:0] root_r_reg;
    logic [QW-1:0] root_h_reg;
    logic [15:0]   angle_reg;

    always_comb
    begin
        test_r = (RW'(in_root_r) << (BIT + 1)) + (RW'(1) << (2 * BIT));
        test_h = (RW'(in_root_h) << (BIT + 1)) + (RW'(1) << (2 * BIT));
        rem_r_next  = in_rem_r;
        root_r_next = in_root_r;
        rem_h_next  = in_rem_h;
        root_h_next = in_root_h;
        if (in_rem_r >= test_r)
        begin
            rem_r_next  = in_rem_r - test_r;
            root_r_next = in_root_r | (QW'(1) << BIT);
        end
        if (in_rem_h >= test_h)
        begin
            rem_h_next  = in_rem_h - test_h;
            root_h_next = in_root_h | (QW'(1) << BIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_r_reg  <= rem_r_next;
        root_r_reg <= root_r_next;
        rem_h_reg  <= rem_h_next;
        root_h_reg <= root_h_next;
        angle_reg  <= in_angle;
    end

    assign out_valid  = valid_reg;
    assign out_rem_r  = rem_r_reg;
    assign out_root_r = root_r_reg;
    assign out_rem_h  = rem_h_reg;
    assign out_root_h = root_h_reg;
    assign out_angle  = angle_reg;
endmodule
`default_nettype wire

// ----- design/chs_cordic_cell.sv -----
// One rotation step of the quarter-turn vector rotator.
`default_nettype none
module chs_cordic_cell #(
    parameter int XW   = 19,
    parameter int ZW   = 34,
    parameter int STEP = 0
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic signed [XW-1:0] in_x,
    input  wire logic signed [XW-1:0] in_y,
    input  wire logic signed [ZW-1:0] in_z,
    input  wire logic [1:0]           in_quad,
    input  wire logic [16:0]          in_height,
    output logic                      out_valid,
    output logic signed [XW-1:0]      out_x,
    output logic signed [XW-1:0]      out_y,
    output logic signed [ZW-1:0]      out_z,
    output logic [1:0]                out_quad,
    output logic [16:0]               out_height
);
    import chs_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = ZW'(atan_turn(STEP));

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_next;
    logic signed [ZW-1:0] z_next;
    logic                 valid_reg;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [1:0]           quad_reg;
    logic [16:0]          height_reg;

    always_comb
    begin
        dx = in_y >>> STEP;
        dy = in_x >>> STEP;
        if (!in_z[ZW-1])
        begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - ATAN;
        end
        else
        begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        quad_reg   <= in_quad;
        height_reg <= in_height;
    end

    assign out_valid  = valid_reg;
    assign out_x      = x_reg;
    assign out_y      = y_reg;
    assign out_z      = z_reg;
    assign out_quad   = quad_reg;
    assign out_height = height_reg;
endmodule
`default_nettype wire

// ----- design/cosine_hemisphere_sampler_unit.sv -----
// Top level of the cosine-weighted hemisphere sampler pipeline.
//
//  channel   | handshake      | payload
//  ----------+----------------+------------------------------
//  request   | start / busy   | chs_pkg::request_t (u_radius, u_angle)
//  result    | done strobe    | chs_pkg::result_t  (dir_x, dir_y, dir_height, density)
//
//  One transfer accepted every cycle; busy is always low.
//  The pipeline runs through an input register, FRAC_BITS + 1 square-root cells,
//  the gain multiply register, CORDIC_STEPS rotation cells and the output register.
//  Reset clears only the valid chain; the datapath carries no state.
//  The receiver cannot stall; done marks each result for one cycle.
`default_nettype none
module cosine_hemisphere_sampler_unit #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire chs_pkg::request_t request,
    output logic                   done,
    output chs_pkg::result_t       result
);
    import chs_pkg::*;

    localparam int F       = FRAC_BITS;
    localparam int S       = CORDIC_STEPS;
    localparam int RW      = 2 * F + 2;
    localparam int QW      = F + 1;
    localparam int XW      = F + 3;
    localparam int ZW      = 34;
    localparam int OW      = XW + 8;
    localparam int LATENCY = F + S + 4;

    logic [RW-1:0] uf_w;
    logic          in_valid_reg;
    logic [RW-1:0] rem_r0_reg;
    logic [RW-1:0] rem_h0_reg;
    logic [15:0]   angle0_reg;

    generate
        if (F >= 16)
        begin : g_uf_up
            assign uf_w = RW'(request.u_radius) << (F - 16);
        end
        else
        begin : g_uf_down
            assign uf_w = RW'(request.u_radius >> (16 - F));
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_r0_reg <= uf_w << F;
        rem_h0_reg <= ((RW'(1) << F) - uf_w) << F;
        angle0_reg <= request.u_angle;
    end

    logic          sq_valid [0:F+1];
    logic [RW-1:0] sq_rem_r [0:F+1];
    logic [QW-1:0] sq_root_r[0:F+1];
    logic [RW-1:0] sq_rem_h [0:F+1];
    logic [QW-1:0] sq_root_h[0:F+1];
    logic [15:0]   sq_angle [0:F+1];

    assign sq_valid[0]  = in_valid_reg;
    assign sq_rem_r[0]  = rem_r0_reg;
    assign sq_root_r[0] = '0;
    assign sq_rem_h[0]  = rem_h0_reg;
    assign sq_root_h[0] = '0;
    assign sq_angle[0]  = angle0_reg;

    genvar k;
    generate
        for (k = 0; k <= F; k++)
        begin : g_sqrt
            chs_sqrt_cell #(.RW(RW), .QW(QW), .BIT(F - k)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (sq_valid[k]),
                .in_rem_r  (sq_rem_r[k]),
                .in_root_r (sq_root_r[k]),
                .in_rem_h  (sq_rem_h[k]),
                .in_root_h (sq_root_h[k]),
                .in_angle  (sq_angle[k]),
                .out_valid (sq_valid[k+1]),
                .out_rem_r (sq_rem_r[k+1]),
                .out_root_r(sq_root_r[k+1]),
                .out_rem_h (sq_rem_h[k+1]),
                .out_root_h(sq_root_h[k+1]),
                .out_angle (sq_angle[k+1])
            );
        end
    endgenerate

    logic [QW+31:0] gain_prod;
    logic [16:0]    h16_raw;
    logic [16:0]    h16_w;
    logic           g_valid_reg;
    logic [QW-1:0]  x0_reg;
    logic [16:0]    h16_reg;
    logic [15:0]    g_angle_reg;

    assign gain_prod = (QW + 32)'(sq_root_r[F+1]) * (QW + 32)'(KGAIN_Q32);

    generate
        if (F > 16)
        begin : g_h_round
            logic [QW:0] h_sum;
            assign h_sum   = (QW + 1)'(sq_root_h[F+1]) + ((QW + 1)'(1) << (F - 17));
            assign h16_raw = (h_sum >> (F - 16)) > (QW + 1)'(HEIGHT_MAX) ?
                             HEIGHT_MAX : h_sum[F:F-16];
        end
        else
        begin : g_h_widen
            assign h16_raw = 17'(sq_root_h[F+1]) << (16 - F);
        end
    endgenerate

    assign h16_w = (h16_raw > HEIGHT_MAX) ? HEIGHT_MAX : h16_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
        end
        else
        begin
            g_valid_reg <= sq_valid[F+1];
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg      <= gain_prod[QW+31:32];
        h16_reg     <= h16_w;
        g_angle_reg <= sq_angle[F+1];
    end

    logic                 cv [0:S];
    logic signed [XW-1:0] cx [0:S];
    logic signed [XW-1:0] cy [0:S];
    logic signed [ZW-1:0] cz [0:S];
    logic [1:0]           cq [0:S];
    logic [16:0]          ch [0:S];

    assign cv[0] = g_valid_reg;
    assign cx[0] = signed'(XW'(x0_reg));
    assign cy[0] = '0;
    assign cz[0] = signed'(ZW'({g_angle_reg[13:0], 16'd0}));
    assign cq[0] = g_angle_reg[15:14];
    assign ch[0] = h16_reg;

    genvar i;
    generate
        for (i = 0; i < S; i++)
        begin : g_cordic
            chs_cordic_cell #(.XW(XW), .ZW(ZW), .STEP(i)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (cv[i]),
                .in_x      (cx[i]),
                .in_y      (cy[i]),
                .in_z      (cz[i]),
                .in_quad   (cq[i]),
                .in_height (ch[i]),
                .out_valid (cv[i+1]),
                .out_x     (cx[i+1]),
                .out_y     (cy[i+1]),
                .out_z     (cz[i+1]),
                .out_quad  (cq[i+1]),
                .out_height(ch[i+1])
            );
        end
    endgenerate

    logic signed [XW-1:0] ox;
    logic signed [XW-1:0] oy;
    logic signed [OW-1:0] ox_e;
    logic signed [OW-1:0] oy_e;
    logic signed [OW-1:0] ox_s;
    logic signed [OW-1:0] oy_s;
    logic [15:0]          ox_q;
    logic [15:0]          oy_q;
    logic [49:0]          dens_prod;
    logic                 done_reg;
    result_t              result_reg;

    always_comb
    begin
        case (cq[S])
            2'd0:
            begin
                ox = cx[S];
                oy = cy[S];
            end
            2'd1:
            begin
                ox = -cy[S];
                oy = cx[S];
            end
            2'd2:
            begin
                ox = -cx[S];
                oy = -cy[S];
            end
            default:
            begin
                ox = cy[S];
                oy = -cx[S];
            end
        endcase
        ox_e = OW'(ox);
        oy_e = OW'(oy);
    end

    generate
        if (F > 15)
        begin : g_q_round
            assign ox_s = (ox_e + (OW'(1) <<< (F - 16))) >>> (F - 15);
            assign oy_s = (oy_e + (OW'(1) <<< (F - 16))) >>> (F - 15);
        end
        else
        begin : g_q_widen
            assign ox_s = ox_e <<< (15 - F);
            assign oy_s = oy_e <<< (15 - F);
        end
    endgenerate

    always_comb
    begin
        if (ox_s > OW'(32767))
            ox_q = 16'h7FFF;
        else if (ox_s < -OW'(32768))
            ox_q = 16'h8000;
        else
            ox_q = ox_s[15:0];
        if (oy_s > OW'(32767))
            oy_q = 16'h7FFF;
        else if (oy_s < -OW'(32768))
            oy_q = 16'h8000;
        else
            oy_q = oy_s[15:0];
        dens_prod = 50'(ch[S]) * 50'(INV_TAU_Q32) + (50'(1) << 31);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cv[S];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.dir_x      <= ox_q;
        result_reg.dir_y      <= oy_q;
        result_reg.dir_height <= ch[S];
        result_reg.density    <= dens_prod[45:32];
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;
endmodule
`default_nettype wire

// ----- design/chs_checker.sv -----
// Port-level checks for the hemisphere sampler, bound to the top level.
`default_nettype none
module chs_checker #(
    parameter int LAT = 36
) (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire chs_pkg::request_t request,
    input wire logic              done,
    input wire chs_pkg::result_t  result
);
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing after transfer");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without transfer");

    a_pole_height: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.u_radius == 16'd0) |->
            ##LAT (result.dir_height == 17'd65536 && result.density == 14'd10430))
        else $error("pole sample wrong");

    a_height_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.dir_height <= 17'd65536)
        else $error("height out of range");
endmodule

bind cosine_hemisphere_sampler_unit chs_checker #(.LAT(LATENCY)) u_chs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
);
`default_nettype wire

// ----- bench/cosine_hemisphere_sampler_unit_test.sv -----
// Self-checking testbench for the cosine hemisphere sampler, scored against a fixed-point predictor.
`timescale 1ns / 1ps
module cosine_hemisphere_sampler_unit_test;
    import chs_pkg::*;

    localparam int FRAC = 16;
    localparam int STEPS = 16;
    localparam int LATENCY = FRAC + STEPS + 4;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    request_t request;
    logic done;
    result_t result;
    int unsigned error_count;
    int unsigned stall_pct;

    cosine_hemisphere_sampler_unit #(.FRAC_BITS(FRAC), .CORDIC_STEPS(STEPS)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .request(request), .done(done), .result(result)
    );

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] round_q15(longint signed v);
        longint signed o;
        o = (v + (64'sd1 << (FRAC - 16))) >>> (FRAC - 15);
        if (o > 32767) o = 32767;
        if (o < -32768) o = -32768;
        return o[15:0];
    endfunction

    function automatic result_t sample_direction(request_t req);
        result_t res;
        longint unsigned uf, r, h, h16, dens;
        longint signed x, y, z, dx, dy, ox, oy;
        logic [1:0] quad;
        uf = 64'(req.u_radius);
        r = int_sqrt(uf << FRAC);
        if (uf == 0) h = 64'd1 << FRAC;
        else h = int_sqrt(((64'd1 << FRAC) - uf) << FRAC);
        h16 = h;
        if (h16 > 65536) h16 = 65536;
        dens = (h16 * 64'(INV_TAU_Q32) + (64'd1 << 31)) >> 32;
        quad = req.u_angle[15:14];
        z = longint'({req.u_angle[13:0], 16'd0});
        x = longint'((r * 64'(KGAIN_Q32)) >> 32);
        y = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(atan_turn(i));
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(atan_turn(i));
            end
        end
        case (quad)
            2'd0: begin ox = x;  oy = y;  end
            2'd1: begin ox = -y; oy = x;  end
            2'd2: begin ox = -x; oy = -y; end
            default: begin ox = y; oy = -x; end
        endcase
        res.dir_x = round_q15(ox);
        res.dir_y = round_q15(oy);
        res.dir_height = h16[16:0];
        res.density = dens[13:0];
        return res;
    endfunction

    class sample_scoreboard;
        result_t expected [0:255];
        int unsigned wr_count;
        int unsigned rd_count;

        function new();
            wr_count = 0;
            rd_count = 0;
        endfunction

        function int unsigned outstanding();
            return wr_count - rd_count;
        endfunction

        function void note_request(request_t req);
            expected[wr_count[7:0]] = sample_direction(req);
            wr_count++;
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (outstanding() == 0)
            begin
                $error("unexpected result %h", got);
                error_count++;
                return;
            end
            exp = expected[rd_count[7:0]];
            rd_count++;
            if (got.dir_x !== exp.dir_x)
            begin
                $error("dir_x expected %0d actual %0d", exp.dir_x, got.dir_x);
                error_count++;
            end
            if (got.dir_y !== exp.dir_y)
            begin
                $error("dir_y expected %0d actual %0d", exp.dir_y, got.dir_y);
                error_count++;
            end
            if (got.dir_height !== exp.dir_height)
            begin
                $error("dir_height expected %0d actual %0d", exp.dir_height, got.dir_height);
                error_count++;
            end
            if (got.density !== exp.density)
            begin
                $error("density expected %0d actual %0d", exp.density, got.density);
                error_count++;
            end
        endfunction
    endclass

    sample_scoreboard board;
    int unsigned idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note_request(request);
            if (done)
                board.check_result(result);
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_sample(logic [15:0] radius, logic [15:0] angle);
        while ($urandom_range(99) < stall_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        request <= '{u_radius: radius, u_angle: angle};
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(int count);
        logic [15:0] a;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(5))
                0: a = {2'($urandom_range(3)), 14'd0};
                1: a = {2'($urandom_range(3)), 14'd0} + 16'($urandom_range(3)) - 16'd1;
                default: a = 16'($urandom);
            endcase
            case ($urandom_range(5))
                0: send_sample(16'($urandom_range(3)), a);
                1: send_sample(16'hFFFF - 16'($urandom_range(3)), a);
                default: send_sample(16'($urandom), a);
            endcase
        end
    endtask

    initial
    begin
        board = new();
        error_count = 0;
        idle_cycles = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_sample(16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'h0000);
        send_sample(16'hFFFF, 16'h4000);
        send_sample(16'hFFFF, 16'h8000);
        send_sample(16'hFFFF, 16'hC000);
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(16'hFFFF, 16'h3FFF);
        send_sample(16'hFFFF, 16'h2000);
        send_sample(16'h0000, 16'hFFFF);
        send_sample(16'h0001, 16'h0001);
        send_sample(16'h8000, 16'h6000);
        send_sample(16'h5555, 16'hAAAA);
        send_sample(16'hAAAA, 16'h5555);
        send_sample(16'hFFFE, 16'hBFFF);
        send_sample(16'h4000, 16'hE000);

        stall_pct = 0;
        send_random(500);
        stall_pct = 50;
        send_random(400);
        stall_pct = 14;
        send_random(400);
        stall_pct = 0;
        send_random(400);
        start <= 1'b0;

        while (board.outstanding() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
